FILE: design/stho_pkg.sv
// Shared constants and types of the parking space tap/hold override controller.
package stho_pkg;

	localparam int SPACE_COUNT = 8;
	localparam int SPACE_AW = (SPACE_COUNT > 1) ? $clog2(SPACE_COUNT) : 1;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [15:0] HOLD_TIME_RESET = 16'd1500;
	localparam logic [15:0] DEBOUNCE_TIME_RESET = 16'd50;
	localparam logic [7:0] HANDICAP_MASK_RESET = 8'd1;
	localparam logic [7:0] RETIRED_MASK_RESET = 8'd16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_HOLD_TIME = 2'd0,
		CFG_DEBOUNCE_TIME = 2'd1,
		CFG_HANDICAP_MASK = 2'd2,
		CFG_RETIRED_MASK = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0] space;
		logic button_down;
		logic sensor_blocked;
		logic [31:0] now_ms;
	} sample_t;

	typedef struct packed {
		logic button_changed;
		logic occupancy_changed;
		logic relabel;
		logic led_red;
		logic led_green;
		logic led_blue;
		logic shown_occupied;
		logic unavailable;
		logic override_on;
	} result_t;

	typedef struct packed {
		logic press_seen;
		logic [31:0] press_start_ms;
		logic hold_done;
		logic maintenance;
		logic manual_on;
		logic manual_occupied;
		logic prior_occupied;
	} space_state_t;

	typedef struct packed {
		logic en;
		logic [SPACE_AW-1:0] addr;
		space_state_t data;
	} state_wr_t;

	typedef struct packed {
		logic en;
		logic [SPACE_AW-1:0] addr;
	} state_rd_t;

endpackage

FILE: design/stho_channels.sv
// Valid/ready channel interfaces for sample words and result words.
interface stho_sample_if;
	logic valid;
	logic ready;
	stho_pkg::sample_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface stho_result_if;
	logic valid;
	logic ready;
	stho_pkg::result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: design/stho_state_mem.sv
// Per-space state memory with registered read, write forwarding and reset valid bits.
module stho_state_mem (
	input logic clk,
	input logic arst_n,
	input stho_pkg::state_rd_t rd,
	input stho_pkg::state_wr_t wr,
	output stho_pkg::space_state_t rd_state
);

	stho_pkg::space_state_t mem_q [stho_pkg::SPACE_COUNT];
	logic [stho_pkg::SPACE_COUNT-1:0] entry_valid_q;
	stho_pkg::space_state_t rd_data_q;
	logic rd_valid_q;
	logic fwd;

	// A write landing on the entry being read at the same edge is passed straight through.
	assign fwd = wr.en && rd.en && (wr.addr == rd.addr);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q <= fwd ? wr.data : mem_q[rd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				entry_valid_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				rd_valid_q <= fwd || entry_valid_q[rd.addr];
			end
		end
	end

	// An entry never written since reset reads as all zeros.
	assign rd_state = rd_valid_q ? rd_data_q : '0;

	a_forward_visible: assert property (@(posedge clk) disable iff (!arst_n)
		fwd |=> (rd_state == $past(wr.data)))
		else $error("forwarded state word not visible on the next read");

endmodule

FILE: design/space_tap_hold_override_control.sv
// Top level of the parking space tap/hold override controller.
// One sample word is taken each clock cycle, back to back, unless a stall holds it up.
// An accepted sample is registered in the update stage, and its result word in the
// output register, where it becomes valid on the result channel. A stalled
// result channel blocks new samples only once the update stage also holds a word.
// The per-space state sits in a small memory with a registered read.
// The state is read when a sample is accepted and updated in the update stage. It is
// written back as the result enters the output register, and that write is
// forwarded to a read of the same space at that edge. Entries read as cleared after
// reset, so no clearing pass is needed. Configuration writes are taken at any cycle
// through the plain write port and should be made only while no sample is in flight.
module space_tap_hold_override_control (
	input logic clk,
	input logic arst_n,
	stho_sample_if.sink sample,
	stho_result_if.source result,
	input logic cfg_we,
	input logic [stho_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [stho_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	logic [15:0] hold_time_q;
	logic [15:0] debounce_time_q;
	logic [7:0] handicap_mask_q;
	logic [7:0] retired_mask_q;

	logic s1_valid_q;
	stho_pkg::sample_t sample_s1;
	logic in_range_s1;

	logic out_valid_q;
	stho_pkg::result_t out_q;

	logic adv;
	logic acc;
	logic in_range;
	stho_pkg::state_rd_t rd;
	stho_pkg::state_wr_t wr;
	stho_pkg::space_state_t cur;
	stho_pkg::space_state_t nxt;
	stho_pkg::result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_time_q <= stho_pkg::HOLD_TIME_RESET;
			debounce_time_q <= stho_pkg::DEBOUNCE_TIME_RESET;
			handicap_mask_q <= stho_pkg::HANDICAP_MASK_RESET;
			retired_mask_q <= stho_pkg::RETIRED_MASK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				stho_pkg::CFG_HOLD_TIME: hold_time_q <= cfg_wdata;
				stho_pkg::CFG_DEBOUNCE_TIME: debounce_time_q <= cfg_wdata;
				stho_pkg::CFG_HANDICAP_MASK: handicap_mask_q <= cfg_wdata[7:0];
				stho_pkg::CFG_RETIRED_MASK: retired_mask_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign adv = !out_valid_q || result.ready;
	assign sample.ready = !s1_valid_q || adv;
	assign acc = sample.valid && sample.ready;
	assign in_range = 32'(sample.data.space) < 32'(stho_pkg::SPACE_COUNT);

	assign rd.en = acc && in_range;
	assign rd.addr = stho_pkg::SPACE_AW'(sample.data.space);

	stho_state_mem u_state_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd(rd),
		.wr(wr),
		.rd_state(cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (sample.ready) begin
				s1_valid_q <= sample.valid;
			end
			if (adv) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			sample_s1 <= sample.data;
			in_range_s1 <= in_range;
		end
		if (adv && s1_valid_q) begin
			out_q <= res;
		end
	end

	always_comb begin
		logic retired;
		logic unavail_pre;
		logic unavail_post;
		logic masked;
		logic pressed;
		logic [31:0] start_base;
		logic [31:0] held_ms;
		logic [31:0] limit_ms;
		logic reached;

		pressed = sample_s1.button_down;
		retired = retired_mask_q[sample_s1.space];
		unavail_pre = retired || cur.maintenance;
		masked = sample_s1.sensor_blocked && !unavail_pre;

		start_base = (pressed && !cur.press_seen) ? sample_s1.now_ms : cur.press_start_ms;
		held_ms = sample_s1.now_ms - start_base;
		limit_ms = pressed ? {16'd0, hold_time_q} : {16'd0, debounce_time_q};
		reached = held_ms >= limit_ms;

		nxt = cur;
		res = '0;

		if (pressed && !cur.press_seen) begin
			nxt.press_seen = 1'b1;
			nxt.press_start_ms = sample_s1.now_ms;
			nxt.hold_done = 1'b0;
		end
		// A hold fires once per press; it flips the availability of a space that is not retired.
		if (pressed && !nxt.hold_done && reached) begin
			nxt.hold_done = 1'b1;
			nxt.maintenance = !unavail_pre;
			nxt.manual_on = 1'b0;
			res.relabel = 1'b1;
			res.button_changed = 1'b1;
		end
		if (!pressed && cur.press_seen) begin
			nxt.press_seen = 1'b0;
			if (!cur.hold_done && reached) begin
				if (unavail_pre) begin
					nxt.maintenance = 1'b0;
					nxt.manual_on = 1'b0;
					res.relabel = 1'b1;
				end else if (!cur.manual_on) begin
					nxt.manual_on = 1'b1;
					nxt.manual_occupied = !masked;
				end else begin
					nxt.manual_on = 1'b0;
				end
				res.button_changed = 1'b1;
			end
		end

		res.occupancy_changed = masked != cur.prior_occupied;
		nxt.prior_occupied = masked;

		unavail_post = retired || nxt.maintenance;
		res.unavailable = unavail_post;
		res.override_on = nxt.manual_on;
		if (unavail_post) begin
			res.shown_occupied = 1'b0;
			res.led_red = 1'b1;
			res.led_green = 1'b1;
		end else begin
			res.shown_occupied = nxt.manual_on ? nxt.manual_occupied : masked;
			if (res.shown_occupied) begin
				res.led_red = 1'b1;
			end else if (handicap_mask_q[sample_s1.space]) begin
				res.led_blue = 1'b1;
			end else begin
				res.led_green = 1'b1;
			end
		end

		if (!in_range_s1) begin
			res = '0;
		end
	end

	assign wr.en = s1_valid_q && adv && in_range_s1;
	assign wr.addr = stho_pkg::SPACE_AW'(sample_s1.space);
	assign wr.data = nxt;

	assign result.valid = out_valid_q;
	assign result.data = out_q;

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !adv) |-> !acc)
		else $error("sample word accepted while the update stage is blocked");

	a_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> !(wr.en && $stable(sample_s1) && !$past(acc)))
		else $error("state written twice for one sample word");

	a_unavail_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.data.unavailable) |->
		(result.data.led_red && result.data.led_green && !result.data.led_blue
		&& !result.data.shown_occupied))
		else $error("unavailable space shows a wrong indicator");

endmodule
